FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with explicit clock and active-low reset.
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion on the block clock and reset.
`define AST(lbl, prop, msg) \
    `AST_CLK(lbl, i_clk, i_rst_n, prop, msg)
`endif

FILE: sv/sal_pkg.sv
// Shared constants and types of the suffix array / LCP builder.
package sal_pkg;
    localparam int    MAX_LEN_DEF = 255;
    localparam logic [7:0] END_MARK = 8'h24;
    localparam logic  CMD_LOAD = 1'b0;
    localparam logic  CMD_READ = 1'b1;

    typedef struct packed {
        logic text;
        logic sa;
        logic isa;
        logic lcp;
    } t_mem_we;

    typedef struct packed {
        logic       valid;
        logic [7:0] start;
        logic [7:0] lcp;
        logic       ok;
    } t_resp;
endpackage

FILE: sv/sal_store.sv
// Text, suffix array, inverse rank and LCP memories, with registered reads.
module sal_store #(
    parameter int AW = 8
) (
    input  logic             i_clk,
    input  sal_pkg::t_mem_we i_we,
    input  logic [AW-1:0]    i_text_wa,
    input  logic [7:0]       i_text_wd,
    input  logic [AW-1:0]    i_text_ra0,
    input  logic [AW-1:0]    i_text_ra1,
    output logic [7:0]       o_text_rd0,
    output logic [7:0]       o_text_rd1,
    input  logic [AW-1:0]    i_sa_wa,
    input  logic [AW-1:0]    i_sa_wd,
    input  logic [AW-1:0]    i_sa_ra,
    output logic [AW-1:0]    o_sa_rd,
    input  logic [AW-1:0]    i_isa_wa,
    input  logic [AW-1:0]    i_isa_wd,
    input  logic [AW-1:0]    i_isa_ra,
    output logic [AW-1:0]    o_isa_rd,
    input  logic [AW-1:0]    i_lcp_wa,
    input  logic [AW-1:0]    i_lcp_wd,
    input  logic [AW-1:0]    i_lcp_ra,
    output logic [AW-1:0]    o_lcp_rd
);
    import sal_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [7:0]    r_text [DEPTH];
    logic [AW-1:0] r_sa   [DEPTH];
    logic [AW-1:0] r_isa  [DEPTH];
    logic [AW-1:0] r_lcp  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.text) begin
            r_text[i_text_wa] <= i_text_wd;
        end
        o_text_rd0 <= r_text[i_text_ra0];
        o_text_rd1 <= r_text[i_text_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.sa) begin
            r_sa[i_sa_wa] <= i_sa_wd;
        end
        o_sa_rd <= r_sa[i_sa_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.isa) begin
            r_isa[i_isa_wa] <= i_isa_wd;
        end
        o_isa_rd <= r_isa[i_isa_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.lcp) begin
            r_lcp[i_lcp_wa] <= i_lcp_wd;
        end
        o_lcp_rd <= r_lcp[i_lcp_ra];
    end
endmodule

FILE: sv/sal_ctrl.sv
// Sequencer: text loading, insertion sort, inverse ranks, Kasai LCP, rank reads.
module sal_ctrl #(
    parameter int MAX_LEN = sal_pkg::MAX_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_cmd,
    input  logic [7:0]     i_data,
    input  logic           i_last,
    input  logic [7:0]     i_rank,
    input  logic           i_out_free,
    output sal_pkg::t_resp o_resp
);
    import sal_pkg::*;

    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int W  = AW + 1;
    localparam int CW = (AW > 8) ? AW : 8;

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_READ      = 15'b000000000000010,
        S_MARK      = 15'b000000000000100,
        S_INS_START = 15'b000000000001000,
        S_INS_CHK   = 15'b000000000010000,
        S_INS_GOT   = 15'b000000000100000,
        S_CMP_RD    = 15'b000000001000000,
        S_CMP_EV    = 15'b000000010000000,
        S_INV_RD    = 15'b000000100000000,
        S_INV_WR    = 15'b000001000000000,
        S_LCP_RD    = 15'b000010000000000,
        S_LCP_R     = 15'b000100000000000,
        S_LCP_J     = 15'b001000000000000,
        S_KC_RD     = 15'b010000000000000,
        S_KC_EV     = 15'b100000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_len, n_len;
    logic          r_built, n_built;
    logic          r_rok, n_rok;
    logic [W-1:0]  r_n, n_n, r_i, n_i, r_pos, n_pos, r_a, n_a, r_b, n_b, r_k, n_k;
    logic [AW-1:0] r_other, n_other, r_r, n_r;

    t_mem_we       w_we;
    logic [AW-1:0] w_text_wa, w_text_ra0, w_text_ra1;
    logic [7:0]    w_text_wd, w_td0, w_td1;
    logic [AW-1:0] w_sa_wa, w_sa_wd, w_sa_ra, w_sad;
    logic [AW-1:0] w_isa_wa, w_isa_wd, w_isa_ra, w_isad;
    logic [AW-1:0] w_lcp_wa, w_lcp_wd, w_lcp_ra, w_lcpd;

    logic          w_acc;
    logic [AW-1:0] w_idx;
    logic [W:0]    w_ik, w_jk;

    assign o_ready = (r_state == S_IDLE) && i_out_free;
    assign w_acc   = i_valid && o_ready;
    assign w_idx   = r_built ? '0 : r_len;
    assign w_ik    = (W + 1)'(r_i) + (W + 1)'(r_k);
    assign w_jk    = (W + 1)'(r_b) + (W + 1)'(r_k);

    sal_store #(.AW(AW)) u_store (
        .i_clk      (i_clk),
        .i_we       (w_we),
        .i_text_wa  (w_text_wa),
        .i_text_wd  (w_text_wd),
        .i_text_ra0 (w_text_ra0),
        .i_text_ra1 (w_text_ra1),
        .o_text_rd0 (w_td0),
        .o_text_rd1 (w_td1),
        .i_sa_wa    (w_sa_wa),
        .i_sa_wd    (w_sa_wd),
        .i_sa_ra    (w_sa_ra),
        .o_sa_rd    (w_sad),
        .i_isa_wa   (w_isa_wa),
        .i_isa_wd   (w_isa_wd),
        .i_isa_ra   (w_isa_ra),
        .o_isa_rd   (w_isad),
        .i_lcp_wa   (w_lcp_wa),
        .i_lcp_wd   (w_lcp_wd),
        .i_lcp_ra   (w_lcp_ra),
        .o_lcp_rd   (w_lcpd)
    );

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_built = r_built;
        n_rok   = r_rok;
        n_n     = r_n;
        n_i     = r_i;
        n_pos   = r_pos;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        n_other = r_other;
        n_r     = r_r;
        w_we       = '0;
        w_text_wa  = '0;
        w_text_wd  = '0;
        w_text_ra0 = AW'(r_a);
        w_text_ra1 = AW'(r_b);
        w_sa_wa    = AW'(r_pos);
        w_sa_wd    = AW'(r_i);
        w_sa_ra    = '0;
        w_isa_wa   = w_sad;
        w_isa_wd   = AW'(r_i);
        w_isa_ra   = AW'(r_i);
        w_lcp_wa   = r_r;
        w_lcp_wd   = AW'(r_k);
        w_lcp_ra   = AW'(i_rank);
        o_resp     = '0;

        unique case (r_state)
            S_IDLE: begin
                w_sa_ra = AW'(i_rank);
                if (w_acc) begin
                    if (i_cmd == CMD_READ) begin
                        n_rok   = r_built && (CW'(i_rank) <= CW'(r_len));
                        n_state = S_READ;
                    end else begin
                        n_built = 1'b0;
                        n_len   = w_idx;
                        if (w_idx < AW'(MAX_LEN)) begin
                            w_we.text = 1'b1;
                            w_text_wa = w_idx;
                            w_text_wd = i_data;
                            n_len     = w_idx + 1'b1;
                        end
                        if (i_last) begin
                            n_state = S_MARK;
                        end
                    end
                end
            end
            S_READ: begin
                o_resp.valid = 1'b1;
                o_resp.ok    = r_rok;
                o_resp.start = r_rok ? 8'(w_sad) : 8'd0;
                o_resp.lcp   = r_rok ? 8'(w_lcpd) : 8'd0;
                n_state      = S_IDLE;
            end
            S_MARK: begin
                // append the end marker and start the sort
                w_we.text = 1'b1;
                w_text_wa = r_len;
                w_text_wd = END_MARK;
                n_n       = W'(r_len) + 1'b1;
                n_i       = '0;
                n_state   = S_INS_START;
            end
            S_INS_START: begin
                if (r_i == r_n) begin
                    n_i     = '0;
                    n_state = S_INV_RD;
                end else begin
                    n_pos   = r_i;
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (r_pos == '0) begin
                    w_we.sa = 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_INS_START;
                end else begin
                    w_sa_ra = AW'(r_pos - 1'b1);
                    n_state = S_INS_GOT;
                end
            end
            S_INS_GOT: begin
                n_other = w_sad;
                n_a     = r_i;
                n_b     = W'(w_sad);
                n_state = S_CMP_RD;
            end
            S_CMP_RD: begin
                if (r_a < r_n && r_b < r_n) begin
                    n_state = S_CMP_EV;
                end else if (r_a >= r_n && r_b < r_n) begin
                    // candidate is a proper prefix: shift the other one up
                    w_we.sa = 1'b1;
                    w_sa_wd = r_other;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_INS_CHK;
                end else begin
                    w_we.sa = 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_INS_START;
                end
            end
            S_CMP_EV: begin
                if (w_td0 == w_td1) begin
                    n_a     = r_a + 1'b1;
                    n_b     = r_b + 1'b1;
                    n_state = S_CMP_RD;
                end else if (w_td0 < w_td1) begin
                    w_we.sa = 1'b1;
                    w_sa_wd = r_other;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_INS_CHK;
                end else begin
                    w_we.sa = 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_INS_START;
                end
            end
            S_INV_RD: begin
                w_sa_ra = AW'(r_i);
                if (r_i == r_n) begin
                    n_i     = '0;
                    n_k     = '0;
                    n_state = S_LCP_RD;
                end else begin
                    n_state = S_INV_WR;
                end
            end
            S_INV_WR: begin
                w_we.isa = 1'b1;
                n_i      = r_i + 1'b1;
                n_state  = S_INV_RD;
            end
            S_LCP_RD: begin
                if (r_i == r_n) begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LCP_R;
                end
            end
            S_LCP_R: begin
                n_r = w_isad;
                if (W'(w_isad) == r_n - 1'b1) begin
                    // last rank has no successor
                    w_we.lcp = 1'b1;
                    w_lcp_wa = w_isad;
                    w_lcp_wd = '0;
                    n_k      = '0;
                    n_i      = r_i + 1'b1;
                    n_state  = S_LCP_RD;
                end else begin
                    w_sa_ra = w_isad + 1'b1;
                    n_state = S_LCP_J;
                end
            end
            S_LCP_J: begin
                n_b     = W'(w_sad);
                n_state = S_KC_RD;
            end
            S_KC_RD: begin
                w_text_ra0 = AW'(w_ik);
                w_text_ra1 = AW'(w_jk);
                if (w_ik < (W + 1)'(r_n) && w_jk < (W + 1)'(r_n)) begin
                    n_state = S_KC_EV;
                end else begin
                    w_we.lcp = 1'b1;
                    n_k      = (r_k != '0) ? r_k - 1'b1 : '0;
                    n_i      = r_i + 1'b1;
                    n_state  = S_LCP_RD;
                end
            end
            S_KC_EV: begin
                if (w_td0 == w_td1) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_KC_RD;
                end else begin
                    w_we.lcp = 1'b1;
                    n_k      = (r_k != '0) ? r_k - 1'b1 : '0;
                    n_i      = r_i + 1'b1;
                    n_state  = S_LCP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_built <= n_built;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rok   <= n_rok;
        r_n     <= n_n;
        r_i     <= n_i;
        r_pos   <= n_pos;
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
        r_other <= n_other;
        r_r     <= n_r;
    end
endmodule

FILE: sv/suffix_array_lcp_builder.sv
// Top level of the suffix array / LCP builder: stream ports and result register.
// Input stream: tuser is the command (0 load, 1 read); tdata carries the text
// byte and the rank; tlast on a load closes the text and starts the build.
// Loads are taken one per cycle while no result waits, and give no result. A
// load after a build starts a new text; bytes beyond MAX_LEN are dropped.
// After the closing byte the block appends 0x24, insertion-sorts all suffixes,
// fills the inverse ranks, then runs Kasai's LCP pass; tready stays low until
// done. The sort dominates the build: each byte comparison is a text memory
// read state followed by a compare state.
// A read returns one result, registered from the S_READ state: start position and
// LCP in tdata, and in tuser a flag that the text is built and the rank is
// within it. The next request is taken only once that result has been taken.
// While the result waits on a low tready, input is held off.
// Reset (synchronous, active low) clears the text length and built flag; the
// memories need no clearing since a read reaches only built entries.
module suffix_array_lcp_builder #(
    parameter int MAX_LEN = sal_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // data_byte[7:0], rank[15:8]
    input  logic        i_s_tlast,
    input  logic        i_s_tuser,  // command[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // start_position[7:0], common_prefix[15:8]
    output logic        o_m_tuser   // valid_res[0]
);
    import sal_pkg::*;
    `include "assert_macros.svh"

    t_resp       w_resp;
    logic        r_m_valid, n_m_valid;
    logic [15:0] r_m_data, n_m_data;
    logic        r_m_user, n_m_user;

    sal_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_data     (i_s_tdata[7:0]),
        .i_last     (i_s_tlast),
        .i_rank     (i_s_tdata[15:8]),
        .i_out_free (!r_m_valid),
        .o_resp     (w_resp)
    );

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        if (w_resp.valid) begin
            n_m_valid = 1'b1;
            n_m_data  = {w_resp.lcp, w_resp.start};
            n_m_user  = w_resp.ok;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    `AST(a_ready_out_free, o_s_tready |-> !o_m_tvalid, "request taken while result pending")
    `AST(a_read_result, (i_s_tvalid && o_s_tready && i_s_tuser == CMD_READ) |-> ##2 o_m_tvalid, "read gave no result")
    `AST(a_load_silent, (i_s_tvalid && o_s_tready && i_s_tuser == CMD_LOAD) |-> ##2 !o_m_tvalid, "load gave a result")
endmodule

FILE: tb/suffix_array_lcp_builder_tb.sv
// Testbench for the suffix array / LCP builder: directed and random stream traffic.
module suffix_array_lcp_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sal_pkg::*;

    localparam int MAX_TEXT   = MAX_LEN_DEF;
    localparam int CYCLE_CAP  = 20_000_000;
    localparam int RAND_ITEMS = 800;

    typedef struct {
        logic [7:0] start;
        logic [7:0] lcp;
        logic       ok;
    } t_rank_info;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // data_byte[7:0], rank[15:8]
    logic        i_s_tlast = 1'b0;
    logic        i_s_tuser = 1'b0; // command[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // start_position[7:0], common_prefix[15:8]
    logic        o_m_tuser;        // valid_res[0]

    suffix_array_lcp_builder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the block's text and tables
    logic [7:0] text_bytes [0:MAX_TEXT];
    int         suffix_order [0:MAX_TEXT];
    int         rank_of [0:MAX_TEXT];
    int         lcp_next [0:MAX_TEXT];
    int         text_len = 0;
    bit         text_built = 1'b0;

    t_rank_info rank_q[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         item_cnt = 0;
    int         err_cnt = 0;
    longint     cycle_cnt = 0;

    function automatic bit suffix_before(int a, int b, int n);
        while (a < n && b < n) begin
            if (text_bytes[a] != text_bytes[b])
                return text_bytes[a] < text_bytes[b];
            a++;
            b++;
        end
        return a >= n && b < n;
    endfunction

    function automatic void build_tables();
        int n;
        int pos;
        int k;
        int r;
        int j;
        n = text_len + 1;
        text_bytes[text_len] = END_MARK;
        for (int i = 0; i < n; i++) begin
            pos = i;
            while (pos > 0 && suffix_before(i, suffix_order[pos-1], n)) begin
                suffix_order[pos] = suffix_order[pos-1];
                pos--;
            end
            suffix_order[pos] = i;
        end
        for (int i = 0; i < n; i++)
            rank_of[suffix_order[i]] = i;
        k = 0;
        for (int i = 0; i < n; i++) begin
            r = rank_of[i];
            if (r == n - 1) begin
                lcp_next[r] = 0;
                k = 0;
            end else begin
                j = suffix_order[r+1];
                while (i + k < n && j + k < n && text_bytes[i+k] == text_bytes[j+k])
                    k++;
                lcp_next[r] = k;
                if (k > 0)
                    k--;
            end
        end
        text_built = 1'b1;
    endfunction

    function automatic void predict_request(logic cmd, logic [7:0] data, logic last,
                                            logic [7:0] rank);
        t_rank_info info;
        if (cmd == CMD_LOAD) begin
            if (text_built) begin
                text_built = 1'b0;
                text_len = 0;
            end
            if (text_len < MAX_TEXT) begin
                text_bytes[text_len] = data;
                text_len++;
            end
            if (last)
                build_tables();
        end else begin
            if (text_built && rank <= text_len) begin
                info.start = suffix_order[rank][7:0];
                info.lcp   = lcp_next[rank][7:0];
                info.ok    = 1'b1;
            end else begin
                info.start = '0;
                info.lcp   = '0;
                info.ok    = 1'b0;
            end
            rank_q = {rank_q, info};
        end
    endfunction

    task automatic send_request(logic cmd, logic [7:0] data, logic last, logic [7:0] rank);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            i_s_tdata  = {8'($urandom_range(255)), 8'($urandom_range(255))};
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = {rank, data};
        i_s_tlast  = last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_request(cmd, data, last, rank);
        item_cnt++;
    endtask

    task automatic load_text(int len, int alpha);
        for (int i = 0; i < len; i++)
            send_request(CMD_LOAD, (alpha >= 256) ? 8'($urandom_range(255))
                                                  : 8'(8'h22 + $urandom_range(alpha - 1)),
                         i == len - 1, 8'($urandom_range(255)));
    endtask

    task automatic read_rank(logic [7:0] rank);
        send_request(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), rank);
    endtask

    task automatic read_all_ranks();
        for (int r = 0; r <= text_len + 1 && r < 256; r++)
            read_rank(8'(r));
    endtask

    task automatic test_directed();
        read_rank(8'd0);
        read_rank(8'd255);
        send_request(CMD_LOAD, 8'h00, 1'b1, 8'hff);
        read_all_ranks();
        read_rank(8'd255);
        // marker byte in the text and extreme byte values
        send_request(CMD_LOAD, 8'hff, 1'b0, 8'h00);
        send_request(CMD_LOAD, 8'h24, 1'b0, 8'h00);
        send_request(CMD_LOAD, 8'h24, 1'b0, 8'hff);
        send_request(CMD_LOAD, 8'h00, 1'b0, 8'h00);
        send_request(CMD_LOAD, 8'hff, 1'b1, 8'h00);
        read_all_ranks();
    endtask

    task automatic test_long_text();
        // over-long text: bytes past the limit are dropped
        load_text(MAX_TEXT + 4, 256);
        read_rank(8'd0);
        read_rank(8'd254);
        read_rank(8'd255);
        for (int i = 0; i < 6; i++)
            read_rank(8'($urandom_range(255)));
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        int stop;
        int len;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        stop = item_cnt + count;
        while (item_cnt < stop) begin
            if ($urandom_range(9) == 0) begin
                // noise: reads at any rank, or a bare load without tlast
                if ($urandom_range(1))
                    read_rank(8'($urandom_range(255)));
                else
                    send_request(CMD_LOAD, 8'($urandom_range(255)), 1'b0,
                                 8'($urandom_range(255)));
            end else begin
                len = ($urandom_range(19) == 0) ? $urandom_range(40, 90)
                                                : $urandom_range(1, 14);
                load_text(len, ($urandom_range(1)) ? 256 : $urandom_range(1, 3));
                for (int i = $urandom_range(2, 8); i > 0; i--)
                    read_rank(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(text_len + 1)));
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (rank_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: tdata=%h tuser=%b", o_m_tdata, o_m_tuser);
            end else begin
                t_rank_info want;
                want = rank_q.pop_front();
                if (o_m_tdata[7:0] !== want.start || o_m_tdata[15:8] !== want.lcp ||
                    o_m_tuser !== want.ok) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: start %0d/%0d lcp %0d/%0d ok %b/%b (exp/got)",
                                 want.start, o_m_tdata[7:0], want.lcp, o_m_tdata[15:8],
                                 want.ok, o_m_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_long_text();
        test_random_phase(0, 0, RAND_ITEMS / 4);
        test_random_phase(72, 0, RAND_ITEMS / 4);
        test_random_phase(0, 72, RAND_ITEMS / 4);
        test_random_phase(23, 23, RAND_ITEMS / 4);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        wait (rank_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
